// ===== rtl/efe_pkg.sv =====
// ----------------------------------------------------------------------------
// efe_pkg
// Shared types and constants for the segment field extractor.
// ----------------------------------------------------------------------------
package efe_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPONENT_SEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_CHAR  = 2'd2;

    // Register reset values: '+', ':', '?'
    localparam logic [7:0] ELEMENT_SEP_RST   = 8'd43;
    localparam logic [7:0] COMPONENT_SEP_RST = 8'd58;
    localparam logic [7:0] RELEASE_CHAR_RST  = 8'd63;

    // Tag plus its separator
    localparam logic [2:0] SKIP_BYTES = 3'd4;
    localparam logic [7:0] COUNT_MAX  = 8'hFF;

    // Output queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_FOUND     = 2'd1,
        KIND_NOT_FOUND = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
    } t_result;

    // Up to two results produced by one input item, res0 first
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res1;
        t_result    res0;
    } t_push;

endpackage

// ===== rtl/efe_parser.sv =====
// ----------------------------------------------------------------------------
// efe_parser
// Per-byte segment scanner: separator counting, capture control and the
// one-byte hold that lets the segment terminator be dropped.
// ----------------------------------------------------------------------------
module efe_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [7:0]                 i_seg_byte,
    input  logic                       i_seg_end,
    input  logic [7:0]                 i_want_element,
    input  logic [7:0]                 i_want_component,
    input  logic                       i_cfg_we,
    input  logic [efe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                 i_cfg_data,
    output efe_pkg::t_push             o_push
);
    import efe_pkg::*;

    // Configuration
    logic [7:0] r_element_sep;
    logic [7:0] r_component_sep;
    logic [7:0] r_release_char;

    // Segment state
    logic [2:0] r_pos,       n_pos;
    logic [7:0] r_prev,      n_prev;
    logic [7:0] r_elem_cnt,  n_elem_cnt;
    logic [7:0] r_comp_cnt,  n_comp_cnt;
    logic       r_capturing, n_capturing;
    logic [7:0] r_held,      n_held;
    logic       r_held_vld,  n_held_vld;
    logic       r_finished,  n_finished;
    t_push      n_push;

    // Next state and results for the item at the input
    always_comb begin
        logic    short_seg;
        logic    escaped;
        logic    fin_cap;
        t_result res;

        n_pos       = r_pos;
        n_prev      = i_seg_byte;
        n_elem_cnt  = r_elem_cnt;
        n_comp_cnt  = r_comp_cnt;
        n_capturing = r_capturing;
        n_held      = r_held;
        n_held_vld  = r_held_vld;
        n_finished  = r_finished;
        n_push      = '0;
        short_seg   = (r_pos < SKIP_BYTES);
        escaped     = (r_prev == r_release_char);
        fin_cap     = 1'b0;
        res         = '0;

        if (!r_finished) begin
            if (short_seg) begin
                if (r_pos == SKIP_BYTES - 3'd1 && i_want_element == 8'd0
                        && i_want_component == 8'd0) begin
                    n_capturing = 1'b1;
                end
                n_pos = r_pos + 3'd1;
            end else if (i_seg_byte == r_element_sep && !escaped) begin
                if (r_capturing) begin
                    fin_cap = 1'b1;
                end else begin
                    n_elem_cnt = (r_elem_cnt == COUNT_MAX) ? r_elem_cnt
                                                           : r_elem_cnt + 8'd1;
                    n_comp_cnt = 8'd0;
                    if (n_elem_cnt == i_want_element && i_want_component == 8'd0) begin
                        n_capturing = 1'b1;
                    end
                end
            end else if (i_seg_byte == r_component_sep && !escaped) begin
                n_comp_cnt = (r_comp_cnt == COUNT_MAX) ? r_comp_cnt
                                                       : r_comp_cnt + 8'd1;
                if (r_capturing) begin
                    fin_cap = 1'b1;
                end else if (r_elem_cnt == i_want_element
                        && n_comp_cnt == i_want_component) begin
                    n_capturing = 1'b1;
                end
            end else if (r_capturing && !i_seg_end) begin
                // shift the new byte into the hold, release the old one
                if (r_held_vld) begin
                    res.kind     = KIND_DATA;
                    res.value    = r_held;
                    n_push.res0  = res;
                    n_push.cnt   = 2'd1;
                end
                n_held     = i_seg_byte;
                n_held_vld = 1'b1;
            end
        end

        // Closing separator, or segment end while capturing
        if (fin_cap || (i_seg_end && !n_finished && n_capturing && !short_seg)) begin
            if (n_held_vld) begin
                res.kind    = KIND_DATA;
                res.value   = n_held;
                n_push.res0 = res;
                res.kind    = KIND_FOUND;
                res.value   = 8'd0;
                n_push.res1 = res;
                n_push.cnt  = 2'd2;
            end else begin
                res.kind    = KIND_FOUND;
                res.value   = 8'd0;
                n_push.res0 = res;
                n_push.cnt  = 2'd1;
            end
            n_held_vld  = 1'b0;
            n_capturing = 1'b0;
            n_finished  = 1'b1;
        end else if (i_seg_end && !n_finished) begin
            res.kind    = KIND_NOT_FOUND;
            res.value   = 8'd0;
            n_push.res0 = res;
            n_push.cnt  = 2'd1;
        end

        // Segment end returns everything to the start state
        if (i_seg_end) begin
            n_pos       = 3'd0;
            n_prev      = 8'd0;
            n_elem_cnt  = 8'd0;
            n_comp_cnt  = 8'd0;
            n_capturing = 1'b0;
            n_held      = 8'd0;
            n_held_vld  = 1'b0;
            n_finished  = 1'b0;
        end

        if (!i_accept) begin
            n_push = '0;
        end
    end

    assign o_push = n_push;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_sep   <= ELEMENT_SEP_RST;
            r_component_sep <= COMPONENT_SEP_RST;
            r_release_char  <= RELEASE_CHAR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ELEMENT_SEP:   r_element_sep   <= i_cfg_data;
                REG_COMPONENT_SEP: r_component_sep <= i_cfg_data;
                REG_RELEASE_CHAR:  r_release_char  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Segment state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 3'd0;
            r_prev      <= 8'd0;
            r_elem_cnt  <= 8'd0;
            r_comp_cnt  <= 8'd0;
            r_capturing <= 1'b0;
            r_held      <= 8'd0;
            r_held_vld  <= 1'b0;
            r_finished  <= 1'b0;
        end else if (i_accept) begin
            r_pos       <= n_pos;
            r_prev      <= n_prev;
            r_elem_cnt  <= n_elem_cnt;
            r_comp_cnt  <= n_comp_cnt;
            r_capturing <= n_capturing;
            r_held      <= n_held;
            r_held_vld  <= n_held_vld;
            r_finished  <= n_finished;
        end
    end

endmodule

// ===== rtl/efe_out_fifo.sv =====
// ----------------------------------------------------------------------------
// efe_out_fifo
// Small result queue: takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module efe_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  efe_pkg::t_push                i_push,
    input  logic                          i_pop,
    output efe_pkg::t_result              o_head,
    output logic                          o_not_empty,
    output logic [efe_pkg::FIFO_CNT_W-1:0] o_count
);
    import efe_pkg::*;

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count,  n_count;
    logic [FIFO_PTR_W-1:0]  wr_ptr_nxt;
    logic                   pop_ok;

    assign pop_ok     = i_pop && (r_count != '0);
    assign wr_ptr_nxt = r_wr_ptr + FIFO_PTR_W'(1);

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(i_push.cnt);
        n_rd_ptr = pop_ok ? r_rd_ptr + FIFO_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + FIFO_CNT_W'(i_push.cnt) - FIFO_CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage: first result at the write pointer, second just after
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr_nxt] <= i_push.res1;
        end
    end

    assign o_head      = r_mem[r_rd_ptr];
    assign o_not_empty = (r_count != '0);
    assign o_count     = r_count;

endmodule

// ===== rtl/edifact_field_extractor_core.sv =====
// ----------------------------------------------------------------------------
// edifact_field_extractor_core
// Streams the bytes of one requested element/component out of each segment.
//
//   Channel   Dir  Handshake                   Contents
//   s_axis    in   tvalid/tready               one segment byte, tlast = end
//   m_axis    out  tvalid/tready               data byte or end-of-field code
//   cfg       in   i_cfg_we (no wait)          separators and release char
//
// One byte accepted per cycle while s_axis_tready is high; results leave one
// per cycle while m_axis_tready is high, via a four-entry queue. A byte that
// closes a field can give two results, so input ready drops while more than
// two queue entries are full. Results enter the queue in the cycle after the
// byte. Reset is synchronous: segment state clears, registers take defaults.
// ----------------------------------------------------------------------------
module edifact_field_extractor_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tdata: [7:0] seg_byte, [15:8] want_element, [23:16] want_component
    input  logic [23:0]                   s_axis_tdata,
    input  logic                          s_axis_tlast,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: [7:0] value
    output logic [7:0]                    m_axis_tdata,
    // tuser: [1:0] kind
    output logic [1:0]                    m_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic                          i_cfg_we,
    input  logic [efe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);
    import efe_pkg::*;

    logic                  accept;
    t_push                 push;
    t_result               head;
    logic                  not_empty;
    logic [FIFO_CNT_W-1:0] count;

    // Room for the worst case of two results
    assign s_axis_tready = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign accept        = s_axis_tvalid && s_axis_tready;

    efe_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_seg_byte       (s_axis_tdata[7:0]),
        .i_seg_end        (s_axis_tlast),
        .i_want_element   (s_axis_tdata[15:8]),
        .i_want_component (s_axis_tdata[23:16]),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_push           (push)
    );

    efe_out_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop       (m_axis_tready),
        .o_head      (head),
        .o_not_empty (not_empty),
        .o_count     (count)
    );

    assign m_axis_tvalid = not_empty;
    assign m_axis_tdata  = head.value;
    assign m_axis_tuser  = head.kind;

endmodule
